// File: design/itp_pkg.sv
package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned SYM_W = 8;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [1:0] prec_t;

  localparam sym_t SYM_PLUS  = 8'h2B;
  localparam sym_t SYM_MINUS = 8'h2D;
  localparam sym_t SYM_MUL   = 8'h2A;
  localparam sym_t SYM_DIV   = 8'h2F;
  localparam sym_t SYM_MOD   = 8'h25;
  localparam sym_t SYM_POW   = 8'h5E;
  localparam sym_t SYM_OPEN  = 8'h28;
  localparam sym_t SYM_CLOSE = 8'h29;

  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_IDLE       = 4'd0;
  localparam upc_t UA_DECODE     = 4'd1;
  localparam upc_t UA_EMIT_SYM   = 4'd2;
  localparam upc_t UA_CLOSE_LP   = 4'd3;
  localparam upc_t UA_CLOSE_CHK  = 4'd4;
  localparam upc_t UA_CLOSE_POP  = 4'd5;
  localparam upc_t UA_CLOSE_HIT  = 4'd6;
  localparam upc_t UA_OPER_LP    = 4'd7;
  localparam upc_t UA_OPER_POP   = 4'd8;
  localparam upc_t UA_PUSH       = 4'd9;
  localparam upc_t UA_FLUSH      = 4'd10;
  localparam upc_t UA_FLUSH_CHK  = 4'd11;
  localparam upc_t UA_FLUSH_POP  = 4'd12;
  localparam upc_t UA_FLUSH_DROP = 4'd13;
  localparam upc_t UA_DONE       = 4'd14;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_DISPATCH,
    C_EMPTY,
    C_TOS_OPEN,
    C_OPER_STOP,
    C_FLUSH_END
  } cond_e;

  typedef struct packed {
    cond_e cond;
    upc_t  target;
    logic  ready;
    logic  load;
    logic  decode;
    logic  pop;
    logic  push;
    logic  emit_sym;
    logic  emit_tos;
    logic  finish;
  } uword_t;

  typedef struct packed {
    logic no_accept;
    logic is_open;
    logic is_close;
    logic is_oper;
    logic empty;
    logic tos_open;
    logic oper_stop;
    logic flush_end;
  } itp_flags_t;

  function automatic logic is_operator(sym_t s);
    return (s == SYM_PLUS) || (s == SYM_MINUS) || (s == SYM_MUL) ||
           (s == SYM_DIV) || (s == SYM_MOD) || (s == SYM_POW);
  endfunction

  function automatic prec_t prec_of(sym_t s);
    prec_t p;
    unique case (s) inside
      SYM_PLUS, SYM_MINUS:         p = 2'd1;
      SYM_MUL, SYM_DIV, SYM_MOD:   p = 2'd2;
      SYM_POW:                     p = 2'd3;
      default:                     p = 2'd0;
    endcase
    return p;
  endfunction

  // microprogram ROM
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    w = '0;
    w.cond = C_NEVER;
    w.target = UA_IDLE;
    unique case (a)
      UA_IDLE: begin
        w.ready = 1'b1; w.load = 1'b1; w.cond = C_NO_ACCEPT; w.target = UA_IDLE;
      end
      UA_DECODE: begin
        w.decode = 1'b1; w.cond = C_DISPATCH;
      end
      UA_EMIT_SYM: begin
        w.emit_sym = 1'b1; w.cond = C_ALWAYS; w.target = UA_FLUSH;
      end
      UA_CLOSE_LP: begin
        w.cond = C_EMPTY; w.target = UA_FLUSH;
      end
      UA_CLOSE_CHK: begin
        w.cond = C_TOS_OPEN; w.target = UA_CLOSE_HIT;
      end
      UA_CLOSE_POP: begin
        w.pop = 1'b1; w.emit_tos = 1'b1; w.cond = C_ALWAYS; w.target = UA_CLOSE_LP;
      end
      UA_CLOSE_HIT: begin
        w.pop = 1'b1; w.cond = C_ALWAYS; w.target = UA_FLUSH;
      end
      UA_OPER_LP: begin
        w.cond = C_OPER_STOP; w.target = UA_PUSH;
      end
      UA_OPER_POP: begin
        w.pop = 1'b1; w.emit_tos = 1'b1; w.cond = C_ALWAYS; w.target = UA_OPER_LP;
      end
      UA_PUSH: begin
        w.push = 1'b1;
      end
      UA_FLUSH: begin
        w.cond = C_FLUSH_END; w.target = UA_DONE;
      end
      UA_FLUSH_CHK: begin
        w.cond = C_TOS_OPEN; w.target = UA_FLUSH_DROP;
      end
      UA_FLUSH_POP: begin
        w.pop = 1'b1; w.emit_tos = 1'b1; w.cond = C_ALWAYS; w.target = UA_FLUSH;
      end
      UA_FLUSH_DROP: begin
        w.pop = 1'b1; w.cond = C_ALWAYS; w.target = UA_FLUSH;
      end
      UA_DONE: begin
        w.finish = 1'b1; w.cond = C_ALWAYS; w.target = UA_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/itp_in_if.sv
interface itp_in_if;
  logic              valid;
  logic              ready;
  itp_pkg::sym_t     symbol;
  logic              end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

// File: design/itp_out_if.sv
interface itp_out_if;
  logic          valid;
  logic          ready;
  itp_pkg::sym_t out_symbol;
  logic          has_symbol;
  logic          last;
  logic          error;

  modport source (output valid, output out_symbol, output has_symbol, output last,
                  output error, input ready);
  modport sink   (input valid, input out_symbol, input has_symbol, input last,
                  input error, output ready);
endinterface

// File: design/itp_useq.sv
module itp_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itp_pkg::itp_flags_t flags_i,
  input  logic                stall_i,
  output itp_pkg::uword_t     uword_o
);

  itp_pkg::upc_t upc_q, upc_d;
  itp_pkg::upc_t disp_tgt;
  logic          taken;

  assign uword_o = itp_pkg::ucode(upc_q);

  always_comb begin
    if (flags_i.is_open) begin
      disp_tgt = itp_pkg::UA_PUSH;
    end else if (flags_i.is_close) begin
      disp_tgt = itp_pkg::UA_CLOSE_LP;
    end else if (flags_i.is_oper) begin
      disp_tgt = itp_pkg::UA_OPER_LP;
    end else begin
      disp_tgt = itp_pkg::UA_EMIT_SYM;
    end
  end

  always_comb begin
    unique case (uword_o.cond)
      itp_pkg::C_NEVER:     taken = 1'b0;
      itp_pkg::C_ALWAYS:    taken = 1'b1;
      itp_pkg::C_NO_ACCEPT: taken = flags_i.no_accept;
      itp_pkg::C_DISPATCH:  taken = 1'b1;
      itp_pkg::C_EMPTY:     taken = flags_i.empty;
      itp_pkg::C_TOS_OPEN:  taken = flags_i.tos_open;
      itp_pkg::C_OPER_STOP: taken = flags_i.oper_stop;
      itp_pkg::C_FLUSH_END: taken = flags_i.flush_end;
      default:              taken = 1'b1;
    endcase
  end

  always_comb begin
    if (stall_i) begin
      upc_d = upc_q;
    end else if (taken) begin
      upc_d = (uword_o.cond == itp_pkg::C_DISPATCH) ? disp_tgt : uword_o.target;
    end else begin
      upc_d = upc_q + itp_pkg::upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= itp_pkg::UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// File: design/itp_stack.sv
module itp_stack #(
  parameter  int unsigned DEPTH = itp_pkg::STACK_DEPTH_DEF,
  localparam int unsigned CW    = $clog2(DEPTH + 1),
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          pop_i,
  input  itp_pkg::sym_t data_i,
  output itp_pkg::sym_t tos_o,
  output logic [CW-1:0] count_o,
  output logic [CW-1:0] open_cnt_o,
  output logic          empty_o,
  output logic          full_o
);

  itp_pkg::sym_t mem_q [DEPTH];
  itp_pkg::sym_t rd_q;
  itp_pkg::sym_t fwd_val_q;
  logic          fwd_q;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] open_q, open_d;
  logic          wr_en;

  assign full_o     = (sp_q == CW'(DEPTH));
  assign empty_o    = (sp_q == '0);
  assign count_o    = sp_q;
  assign open_cnt_o = open_q;
  assign wr_en      = push_i && !full_o;
  // a push shows its value on the top for the cycle the RAM read still misses it
  assign tos_o      = fwd_q ? fwd_val_q : rd_q;

  always_comb begin
    sp_d   = sp_q;
    open_d = open_q;
    if (wr_en) begin
      sp_d = sp_q + CW'(1);
      if (data_i == itp_pkg::SYM_OPEN) begin
        open_d = open_q + CW'(1);
      end
    end else if (pop_i) begin
      sp_d = sp_q - CW'(1);
      if (tos_o == itp_pkg::SYM_OPEN) begin
        open_d = open_q - CW'(1);
      end
    end
  end

  assign rd_ptr = sp_d - CW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[sp_q[AW-1:0]] <= data_i;
    end
    rd_q      <= mem_q[rd_ptr[AW-1:0]];
    fwd_val_q <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= '0;
      open_q <= '0;
      fwd_q  <= 1'b0;
    end else begin
      sp_q   <= sp_d;
      open_q <= open_d;
      fwd_q  <= wr_en;
    end
  end

endmodule

// File: design/itp_outbuf.sv
module itp_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          emit_i,
  input  itp_pkg::sym_t emit_data_i,
  input  logic          finish_i,
  input  logic          eoe_i,
  input  logic          err_i,
  output logic          stall_o,
  itp_out_if.source     out_o
);

  // one symbol is held back so that the final one can carry last
  logic          hold_v_q;
  itp_pkg::sym_t hold_sym_q;
  logic          out_v_q;
  itp_pkg::sym_t out_sym_q;
  logic          out_has_q;
  logic          out_last_q;
  logic          out_err_q;
  logic          free;
  logic          need_out;
  logic          go;

  assign free     = !out_v_q || out_o.ready;
  assign need_out = (emit_i && hold_v_q) || (finish_i && (hold_v_q || eoe_i));
  assign stall_o  = need_out && !free;
  assign go       = need_out && free;

  assign out_o.valid      = out_v_q;
  assign out_o.out_symbol = out_sym_q;
  assign out_o.has_symbol = out_has_q;
  assign out_o.last       = out_last_q;
  assign out_o.error      = out_err_q;

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_err_q <= err_i;
      if (emit_i) begin
        out_sym_q  <= hold_sym_q;
        out_has_q  <= 1'b1;
        out_last_q <= 1'b0;
      end else if (hold_v_q) begin
        out_sym_q  <= hold_sym_q;
        out_has_q  <= 1'b1;
        out_last_q <= eoe_i;
      end else begin
        out_sym_q  <= '0;
        out_has_q  <= 1'b0;
        out_last_q <= 1'b1;
      end
    end
    if (emit_i && !stall_o) begin
      hold_sym_q <= emit_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      if (go) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (emit_i && !stall_o) begin
        hold_v_q <= 1'b1;
      end else if (finish_i && !stall_o) begin
        hold_v_q <= 1'b0;
      end
    end
  end

endmodule

// File: design/infix_to_postfix_converter.sv
// Shunting-yard converter run by a 15-word microprogram, one microword per cycle unless
// the output stalls. Per input beat: an operand is emitted, a '(' is pushed, an operator
// pops entries before it is pushed, a ')' pops entries down to its '(', and the
// end-of-expression flush pops the rest; a busy output stalls the sequencer.
// Reset: asynchronous, active low; stack pointer, error flag, sequencer and output
// valid clear at once, the stack RAM is not cleared.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  itp_in_if.sink    in_i,
  itp_out_if.source out_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  itp_pkg::uword_t     uw;
  itp_pkg::itp_flags_t flags;
  itp_pkg::sym_t       sym_q;
  itp_pkg::sym_t       tos;
  itp_pkg::sym_t       emit_data;
  logic                eoe_q;
  logic                err_q, err_d;
  logic                stall;
  logic                stk_push, stk_pop;
  logic                stk_empty, stk_full;
  logic [CW-1:0]       stk_cnt;
  logic [CW-1:0]       open_cnt;
  logic                is_open, is_close, is_oper;
  logic                tos_ge;
  logic                ovf, unmatched, eoe_err;
  logic                done_eoe;

  assign is_open  = (sym_q == itp_pkg::SYM_OPEN);
  assign is_close = (sym_q == itp_pkg::SYM_CLOSE);
  assign is_oper  = itp_pkg::is_operator(sym_q);
  assign tos_ge   = (itp_pkg::prec_of(tos) >= itp_pkg::prec_of(sym_q));

  assign flags.no_accept = !in_i.valid;
  assign flags.is_open   = is_open;
  assign flags.is_close  = is_close;
  assign flags.is_oper   = is_oper;
  assign flags.empty     = stk_empty;
  assign flags.tos_open  = (tos == itp_pkg::SYM_OPEN);
  assign flags.oper_stop = stk_empty || !tos_ge;
  assign flags.flush_end = !eoe_q || stk_empty;

  // the error of the whole beat is known before the first pop
  assign ovf       = stk_full && (is_open || (is_oper && !tos_ge));
  assign unmatched = is_close && (open_cnt == '0);
  assign eoe_err   = eoe_q && (is_open ||
                     (is_close ? (open_cnt > CW'(1)) : (open_cnt != '0)));
  assign err_d     = err_q || ovf || unmatched || eoe_err;

  assign in_i.ready = uw.ready;
  assign stk_push   = uw.push;
  assign stk_pop    = uw.pop && !stall;
  assign emit_data  = uw.emit_sym ? sym_q : tos;
  assign done_eoe   = uw.finish && eoe_q && !stall;

  itp_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .stall_i (stall),
    .uword_o (uw)
  );

  itp_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (stk_push),
    .pop_i      (stk_pop),
    .data_i     (sym_q),
    .tos_o      (tos),
    .count_o    (stk_cnt),
    .open_cnt_o (open_cnt),
    .empty_o    (stk_empty),
    .full_o     (stk_full)
  );

  itp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (uw.emit_sym || uw.emit_tos),
    .emit_data_i (emit_data),
    .finish_i    (uw.finish),
    .eoe_i       (eoe_q),
    .err_i       (err_q),
    .stall_o     (stall),
    .out_o       (out_o)
  );

  always_ff @(posedge clk_i) begin
    if (uw.load && in_i.valid) begin
      sym_q <= in_i.symbol;
      eoe_q <= in_i.end_of_expr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (uw.decode) begin
      err_q <= err_d;
    end else if (done_eoe) begin
      err_q <= 1'b0;
    end
  end

  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stk_push && stk_pop))
    else $error("stack push and pop in the same cycle");

  a_open_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_cnt <= stk_cnt)
    else $error("open bracket count exceeds stack fill");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_eoe |=> (stk_cnt == '0) && !err_q)
    else $error("state not cleared after end of expression");

endmodule
